// ===== rtl/core/pbrld_pkg.sv =====
package pbrld_pkg;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_REPEAT  = 2'd2
  } mode_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_REPEAT = 1'b1
  } seq_state_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_TRUNC    = 2'd2;

  // Header code that starts no run at all.
  localparam logic [7:0] HDR_NOP = 8'h80;

  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 3;

endpackage

// ===== rtl/core/pbrld_count_unit.sv =====
module pbrld_count_unit #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic [COUNT_BITS-1:0] base,
  input  logic [7:0]            addend,
  input  logic [31:0]           cap,
  output logic [COUNT_BITS-1:0] sum,
  output logic                  over
);

  localparam int unsigned SUM_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

  logic [SUM_W-1:0] sum_full;

  // One adder serves both the capacity check of a header and the count
  // update of every emitted result; the compare runs on the unwrapped sum.
  assign sum_full = SUM_W'(base) + SUM_W'(addend);
  assign over     = sum_full > SUM_W'(cap);
  assign sum      = sum_full[COUNT_BITS-1:0];

endmodule

// ===== rtl/core/packbits_run_length_decoder.sv =====
// Header and literal bytes are taken one per cycle while the output slot is free;
// a result enters the output register in the cycle after its source byte is taken.
// The data byte of a repeat run holds off the input until the run is expanded,
// with up to two decoded bytes per cycle carried by the free output register.
// Synchronous active-low reset: decoder idle, count and error cleared,
// capacity set to all ones.
module packbits_run_length_decoder #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] src_byte
  input  logic        in_tuser,   // [0] image_start
  input  logic        in_tlast,   // strip_last
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte_a, [15:8] out_byte_b, [17:16] count of valid bytes,
  // [49:18] bytes_written, [55:50] zero
  output logic [pbrld_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] strip_end, [2:1] error_code
  output logic [pbrld_pkg::OUT_USER_W-1:0] out_tuser,
  output logic        out_tlast   // run_last
);

  pbrld_pkg::seq_state_t state_r, state_nxt;
  pbrld_pkg::mode_t      mode_r, mode_nxt;
  logic [7:0]            rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [1:0]            err_r, err_nxt;
  logic [7:0]            pend_r, pend_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [31:0]           cap_r, cap_nxt;
  logic [7:0]            rep_left_r, rep_left_nxt;
  logic [7:0]            rep_byte_r, rep_byte_nxt;
  logic                  rep_last_r, rep_last_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_a_r, out_a_nxt;
  logic [7:0]            out_b_r, out_b_nxt;
  logic [1:0]            out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_send_r, out_send_nxt;
  logic [31:0]           out_wr_r, out_wr_nxt;
  logic [1:0]            out_err_r, out_err_nxt;

  logic                  slot_free;
  logic                  acc;
  logic [COUNT_BITS-1:0] base;
  logic [7:0]            addend;
  logic [COUNT_BITS-1:0] sum;
  logic                  over;
  logic [7:0]            need;
  logic [7:0]            rem_dec;
  logic [1:0]            rep_cnt;
  logic                  load;
  logic                  go_rep;
  pbrld_pkg::mode_t      mode_e;
  logic [7:0]            rem_e;
  logic                  pend_v_e;
  logic [1:0]            err_e;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == pbrld_pkg::ST_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;

  // An image start clears the count before this byte is handled.
  assign base = ((state_r == pbrld_pkg::ST_IDLE) && in_tuser) ? '0 : total_r;

  pbrld_count_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_count (
    .base  (base),
    .addend(addend),
    .cap   (cap_r),
    .sum   (sum),
    .over  (over)
  );

  always_comb begin
    priority if (in_tdata < pbrld_pkg::HDR_NOP) begin
      need = in_tdata + 8'd1;
    end else if (in_tdata == pbrld_pkg::HDR_NOP) begin
      need = 8'd0;
    end else begin
      need = 8'(9'd257 - {1'b0, in_tdata});
    end
  end

  assign mode_e   = in_tuser ? pbrld_pkg::MODE_HEADER : mode_r;
  assign rem_e    = in_tuser ? 8'd0 : rem_r;
  assign pend_v_e = in_tuser ? 1'b0 : pend_v_r;
  assign err_e    = in_tuser ? pbrld_pkg::ERR_NONE : err_r;
  assign rem_dec  = (rem_e != 8'd0) ? rem_e - 8'd1 : 8'd0;
  assign rep_cnt  = (rep_left_r >= 8'd2) ? 2'd2 : 2'd1;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    rem_nxt       = rem_r;
    total_nxt     = total_r;
    err_nxt       = err_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    cap_nxt       = cfg_wr_en ? cfg_wr_data : cap_r;
    rep_left_nxt  = rep_left_r;
    rep_byte_nxt  = rep_byte_r;
    rep_last_nxt  = rep_last_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_send_nxt  = out_send_r;
    out_wr_nxt    = out_wr_r;
    out_err_nxt   = out_err_r;
    addend        = 8'd0;
    load          = 1'b0;
    go_rep        = 1'b0;

    unique case (state_r)
      pbrld_pkg::ST_IDLE: begin
        if (acc) begin
          mode_nxt   = mode_e;
          rem_nxt    = rem_e;
          pend_v_nxt = pend_v_e;
          err_nxt    = err_e;
          total_nxt  = base;
          out_a_nxt  = 8'd0;
          out_b_nxt  = 8'd0;
          out_cnt_nxt = 2'd0;
          if (err_e == pbrld_pkg::ERR_NONE) begin
            unique case (mode_e)
              pbrld_pkg::MODE_LITERAL: begin
                rem_nxt = rem_dec;
                if (pend_v_e) begin
                  load        = 1'b1;
                  addend      = 8'd2;
                  out_a_nxt   = pend_r;
                  out_b_nxt   = in_tdata;
                  out_cnt_nxt = 2'd2;
                  pend_v_nxt  = 1'b0;
                  total_nxt   = sum;
                end else if (rem_dec == 8'd0) begin
                  load        = 1'b1;
                  addend      = 8'd1;
                  out_a_nxt   = in_tdata;
                  out_cnt_nxt = 2'd1;
                  total_nxt   = sum;
                end else begin
                  pend_nxt   = in_tdata;
                  pend_v_nxt = 1'b1;
                end
                if (rem_dec == 8'd0) begin
                  mode_nxt = pbrld_pkg::MODE_HEADER;
                end
              end
              pbrld_pkg::MODE_REPEAT: begin
                go_rep       = 1'b1;
                rep_left_nxt = rem_e;
                rep_byte_nxt = in_tdata;
                mode_nxt     = pbrld_pkg::MODE_HEADER;
                rem_nxt      = 8'd0;
              end
              default: begin
                // Header byte; an unused mode code is read as a header too.
                mode_nxt = pbrld_pkg::MODE_HEADER;
                if (need != 8'd0) begin
                  addend = need;
                  if (over) begin
                    err_nxt = pbrld_pkg::ERR_OVERFLOW;
                  end else begin
                    rem_nxt  = need;
                    mode_nxt = in_tdata[7] ? pbrld_pkg::MODE_REPEAT
                                           : pbrld_pkg::MODE_LITERAL;
                  end
                end
              end
            endcase
          end
          if (in_tlast) begin
            if ((err_nxt == pbrld_pkg::ERR_NONE) && (mode_nxt != pbrld_pkg::MODE_HEADER)) begin
              err_nxt = pbrld_pkg::ERR_TRUNC;
            end
            mode_nxt   = pbrld_pkg::MODE_HEADER;
            rem_nxt    = 8'd0;
            pend_v_nxt = 1'b0;
            // The end of a strip always reports, with an empty result if needed.
            if (!go_rep) begin
              load = 1'b1;
            end
          end
          rep_last_nxt = in_tlast;
          if (go_rep) begin
            state_nxt = pbrld_pkg::ST_REPEAT;
          end
          if (load) begin
            out_last_nxt = 1'b1;
            out_send_nxt = in_tlast;
            out_wr_nxt   = 32'(total_nxt);
            out_err_nxt  = err_nxt;
          end
        end
      end
      pbrld_pkg::ST_REPEAT: begin
        if (slot_free) begin
          load         = 1'b1;
          addend       = {6'd0, rep_cnt};
          total_nxt    = sum;
          rep_left_nxt = rep_left_r - {6'd0, rep_cnt};
          out_a_nxt    = rep_byte_r;
          out_b_nxt    = (rep_cnt == 2'd2) ? rep_byte_r : 8'd0;
          out_cnt_nxt  = rep_cnt;
          out_last_nxt = (rep_left_nxt == 8'd0);
          out_send_nxt = (rep_left_nxt == 8'd0) && rep_last_r;
          out_wr_nxt   = 32'(sum);
          out_err_nxt  = err_r;
          if (rep_left_nxt == 8'd0) begin
            state_nxt = pbrld_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = pbrld_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbrld_pkg::ST_IDLE;
      mode_r      <= pbrld_pkg::MODE_HEADER;
      rem_r       <= 8'd0;
      total_r     <= '0;
      err_r       <= pbrld_pkg::ERR_NONE;
      pend_v_r    <= 1'b0;
      cap_r       <= 32'hFFFF_FFFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      rem_r       <= rem_nxt;
      total_r     <= total_nxt;
      err_r       <= err_nxt;
      pend_v_r    <= pend_v_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    rep_left_r <= rep_left_nxt;
    rep_byte_r <= rep_byte_nxt;
    rep_last_r <= rep_last_nxt;
    out_a_r    <= out_a_nxt;
    out_b_r    <= out_b_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
    out_send_r <= out_send_nxt;
    out_wr_r   <= out_wr_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_wr_r, out_cnt_r, out_b_r, out_a_r};
  assign out_tuser  = {out_err_r, out_send_r};
  assign out_tlast  = out_last_r;

endmodule
